// File: design/bfnv_pkg.sv
// shared constants and controller/datapath interface types for the bloom filter core
package bfnv_pkg;

  localparam int HASH_W      = 32;
  localparam int SIZE_CFG_W  = 13;
  localparam int COUNT_CFG_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [HASH_W-1:0] FNV_BASIS     = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME     = 32'd16777619;
  localparam logic [HASH_W-1:0] PROBE_STRIDE  = 32'h9e37_79b9;
  localparam logic [HASH_W-1:0] WRAP_DIVIDEND = 32'hffff_ffff;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 2'd1;

  localparam logic [SIZE_CFG_W-1:0]  FILTER_SIZE_RST = 13'd4096;
  localparam logic [COUNT_CFG_W-1:0] HASH_COUNT_RST  = 5'd4;

  typedef enum logic [1:0] {
    DIV_KEY,
    DIV_STRIDE,
    DIV_WRAP
  } div_src_e;

  typedef struct packed {
    logic      byte_take;
    logic      clr_en;
    logic      div_start;
    div_src_e  div_src;
    logic      load_sm;
    logic      load_tm;
    logic      load_r0;
    logic      probe;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic last_probe;
    logic count_zero;
    logic size_wr;
    logic key_add;
  } dp_status_t;

endpackage

// File: design/bfnv_ram.sv
// generic single write port, single read port ram with registered read
module bfnv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bfnv_div.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module bfnv_div #(
  parameter int SIZE_W = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfnv_pkg::HASH_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0]           divisor_i,
  output logic                        done_o,
  output logic [SIZE_W-1:0]           rem_o
);
  import bfnv_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HASH_W-1:0] dvd_q;
  logic [SIZE_W-1:0] dvs_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] rem_d;

  // partial remainder stays below the divisor, so the trial fits one extra bit
  always_comb begin
    trial = {rem_q, dvd_q[HASH_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = SIZE_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: design/bfnv_dp.sv
// datapath: fnv-1a hashing, config registers, probe position stepping and the bit store
module bfnv_dp #(
  parameter int FILTER_BITS = 4096,
  parameter int MAX_HASHES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfnv_pkg::dp_cmd_t               cmd_i,
  output bfnv_pkg::dp_status_t            status_o,
  input  logic                            cfg_we_i,
  input  logic [bfnv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfnv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            mode_i,
  input  logic [7:0]                      key_byte_i,
  input  logic                            last_byte_i,
  output logic                            present_o
);
  import bfnv_pkg::*;

  localparam int AW = $clog2(FILTER_BITS);
  localparam int SW = $clog2(FILTER_BITS + 1);
  localparam int CW = $clog2(MAX_HASHES + 1);

  logic [SIZE_CFG_W-1:0]  filter_size_q;
  logic [COUNT_CFG_W-1:0] hash_count_q;
  logic [HASH_W-1:0]      run_q;
  logic [HASH_W-1:0]      key_hash_q;
  logic                   mode_q;
  logic                   all_set_q;
  logic                   present_q;
  logic                   chk_q;
  logic [AW-1:0]          clr_q;
  logic [CW-1:0]          idx_q;
  logic [SW-1:0]          sm_q;
  logic [SW-1:0]          tm_q;
  logic [SW-1:0]          r_q;
  logic [HASH_W-1:0]      s_q;

  logic [HASH_W-1:0] h_mix;
  logic [HASH_W-1:0] h_next;
  logic [31:0]       fs_ext;
  logic [31:0]       size_ext;
  logic [31:0]       hc_ext;
  logic [31:0]       count_ext;
  logic [SW-1:0]     size;
  logic [CW-1:0]     count;
  logic [HASH_W-1:0] dividend;
  logic              div_done;
  logic [SW-1:0]     div_rem;
  logic [SW:0]       sum;
  logic [SW-1:0]     t1;
  logic [SW-1:0]     r_next;
  logic              carry;
  logic [HASH_W-1:0] s_next;
  logic [SW:0]       wrap_inc;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_rdata;

  // fnv-1a step: xor the byte, then multiply by the prime (32-bit wrap)
  assign h_mix  = run_q ^ {24'd0, key_byte_i};
  assign h_next = h_mix * FNV_PRIME;

  // effective modulus and probe count after saturation
  always_comb begin
    fs_ext = 32'(filter_size_q);
    if (fs_ext == 32'd0) begin
      size_ext = 32'd1;
    end else if (fs_ext > 32'(FILTER_BITS)) begin
      size_ext = 32'(FILTER_BITS);
    end else begin
      size_ext = fs_ext;
    end
    hc_ext = 32'(hash_count_q);
    if (hc_ext > 32'(MAX_HASHES)) begin
      count_ext = 32'(MAX_HASHES);
    end else begin
      count_ext = hc_ext;
    end
  end

  assign size  = size_ext[SW-1:0];
  assign count = count_ext[CW-1:0];

  always_comb begin
    case (cmd_i.div_src)
      DIV_KEY:    dividend = h_next;
      DIV_STRIDE: dividend = PROBE_STRIDE;
      DIV_WRAP:   dividend = WRAP_DIVIDEND;
      default:    dividend = h_next;
    endcase
  end

  bfnv_div #(
    .SIZE_W(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (size),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // next position: add stride mod size, and take back 2^32 mod size when the sum wraps
  always_comb begin
    sum = {1'b0, r_q} + {1'b0, sm_q};
    if (sum >= {1'b0, size}) begin
      t1 = SW'(sum - {1'b0, size});
    end else begin
      t1 = sum[SW-1:0];
    end
    {carry, s_next} = {1'b0, s_q} + {1'b0, PROBE_STRIDE};
    if (!carry) begin
      r_next = t1;
    end else if (t1 >= tm_q) begin
      r_next = t1 - tm_q;
    end else begin
      r_next = SW'({1'b0, t1} + {1'b0, size} - {1'b0, tm_q});
    end
    // 2^32 mod size from (2^32 - 1) mod size
    wrap_inc = {1'b0, div_rem} + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_size_q <= FILTER_SIZE_RST;
      hash_count_q  <= HASH_COUNT_RST;
      run_q         <= FNV_BASIS;
      clr_q         <= '0;
      idx_q         <= '0;
      chk_q         <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_FILTER_SIZE) begin
        filter_size_q <= cfg_data_i[SIZE_CFG_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_HASH_COUNT) begin
        hash_count_q <= cfg_data_i[COUNT_CFG_W-1:0];
      end
      if (cmd_i.byte_take) begin
        run_q <= last_byte_i ? FNV_BASIS : h_next;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load_r0) begin
        idx_q <= '0;
      end else if (cmd_i.probe) begin
        idx_q <= idx_q + 1'b1;
      end
      chk_q <= cmd_i.probe && !mode_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_take && last_byte_i) begin
      key_hash_q <= h_next;
      mode_q     <= mode_i;
      all_set_q  <= 1'b1;
    end else if (chk_q && !ram_rdata) begin
      all_set_q <= 1'b0;
    end
    if (cmd_i.load_sm) begin
      sm_q <= div_rem;
    end
    if (cmd_i.load_tm) begin
      tm_q <= (wrap_inc == {1'b0, size}) ? '0 : wrap_inc[SW-1:0];
    end
    if (cmd_i.load_r0) begin
      r_q <= div_rem;
      s_q <= key_hash_q;
    end else if (cmd_i.probe) begin
      r_q <= r_next;
      s_q <= s_next;
    end
    if (cmd_i.out_load) begin
      present_q <= all_set_q;
    end
  end

  assign ram_we    = cmd_i.clr_en || (cmd_i.probe && mode_q);
  assign ram_waddr = cmd_i.clr_en ? clr_q : r_q[AW-1:0];

  bfnv_ram #(
    .WIDTH(1),
    .DEPTH(FILTER_BITS)
  ) u_bits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (!cmd_i.clr_en),
    .raddr_i (r_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.div_done   = div_done;
  assign status_o.clr_last   = (clr_q == AW'(FILTER_BITS - 1));
  assign status_o.last_probe = (({1'b0, idx_q} + 1'b1) == {1'b0, count});
  assign status_o.count_zero = (count == '0);
  assign status_o.size_wr    = cfg_we_i && (cfg_index_i == CFG_FILTER_SIZE);
  assign status_o.key_add    = mode_q;

  assign present_o = present_q;

endmodule

// File: design/bfnv_ctrl.sv
// controller: sequences clear pass, modulus precompute, key remainder and probe steps
module bfnv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_byte_i,
  input  logic                 cfg_valid_i,
  input  logic                 out_ready_i,
  input  bfnv_pkg::dp_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output bfnv_pkg::dp_cmd_t    cmd_o
);
  import bfnv_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PRE_S  = 3'd2;
  localparam logic [2:0] ST_PRE_T  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_PROBE  = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;
  logic       out_valid_q, out_valid_d;
  logic       take;

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_q && !cfg_valid_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    pend_d            = pend_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    cmd_o             = '0;
    cmd_o.div_src     = DIV_KEY;
    cmd_o.byte_take   = take;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pend_q) begin
          // modulus changed: redo stride and wrap remainders
          pend_d          = 1'b0;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_STRIDE;
          state_d         = ST_PRE_S;
        end else if (take && last_byte_i) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_KEY;
          state_d         = ST_DIV;
        end
      end
      ST_PRE_S: begin
        if (status_i.div_done) begin
          cmd_o.load_sm   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_WRAP;
          state_d         = ST_PRE_T;
        end
      end
      ST_PRE_T: begin
        if (status_i.div_done) begin
          cmd_o.load_tm = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.load_r0 = 1'b1;
          state_d       = status_i.count_zero ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (status_i.last_probe) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data lands here
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.key_add) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    if (status_i.size_wr) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pend_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/bloom_filter_fnv1a_core.sv
// bloom filter with fnv-1a key hashing: top level joining controller and datapath
// a final key byte starts the bit-serial remainder of its hash and then one bit-store access per
// probe, a query answer going to the output register after the last read; the answer may wait in
// the output register while new bytes are taken; after reset a clearing pass empties every
// location of the bit store, then the stride and wrap remainders are precomputed, as after a
// filter_size write
module bloom_filter_fnv1a_core #(
  parameter int FILTER_BITS = 4096,
  parameter int MAX_HASHES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [7:0]                      key_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            present_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfnv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfnv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfnv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bfnv_dp #(
    .FILTER_BITS(FILTER_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .key_byte_i  (key_byte_i),
    .last_byte_i (last_byte_i),
    .present_o   (present_o)
  );

  bfnv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // a final byte starts a probe sequence, so the next transfer must wait
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> !in_ready_o)
    else $error("input taken right after a final key byte");

  // a new result only loads when the output register is free or being drained
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // clearing, probing and remainder start never overlap
  a_exclusive_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_en, cmd.probe, cmd.div_start}))
    else $error("overlapping datapath operations");

endmodule

// File: sim/testbench.sv
// testbench for the bloom filter core: predicting scoreboard, random key traffic, stalls on both sides
module testbench;
  import bfnv_pkg::*;

  localparam int FILTER_N      = 4096;
  localparam int HASH_MAX      = 16;
  localparam int KEY_MAX       = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int NUM_PHASES    = 9;

  localparam logic [31:0] FNV_OFFSET  = 32'd2166136261;
  localparam logic [31:0] FNV_MULT    = 32'd16777619;
  localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_ADD   = 1'b1;

  typedef struct packed {
    logic [4:0]           len;
    logic [8*KEY_MAX-1:0] data;
  } key_t;

  class bloom_scoreboard;
    bit          filter_bits [FILTER_N];
    logic [31:0] hash_acc;
    logic [12:0] size_reg;
    logic [4:0]  count_reg;
    bit          present_q [$];
    int          errors;
    int          checked;

    function new();
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      hash_acc  = FNV_OFFSET;
      size_reg  = 13'd4096;
      count_reg = 5'd4;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FILTER_SIZE) size_reg = data[12:0];
      else if (idx == CFG_HASH_COUNT) count_reg = data[4:0];
    endfunction

    function void note_byte(logic add, logic [7:0] kbyte, logic last);
      logic [31:0] h;
      logic [31:0] modulus;
      logic [31:0] pos;
      int unsigned probes;
      bit          all_set;
      h = (hash_acc ^ {24'd0, kbyte}) * FNV_MULT;
      if (!last) begin
        hash_acc = h;
        return;
      end
      hash_acc = FNV_OFFSET;
      // zero size acts as one bit, oversize saturates at the store depth
      modulus = (size_reg == 0) ? 32'd1 : (size_reg > FILTER_N) ? FILTER_N : size_reg;
      probes  = (count_reg > HASH_MAX) ? HASH_MAX : count_reg;
      all_set = 1'b1;
      for (int unsigned i = 0; i < probes; i++) begin
        pos = (h + i * GOLDEN_STEP) % modulus;
        if (add) filter_bits[pos] = 1'b1;
        else if (!filter_bits[pos]) all_set = 1'b0;
      end
      if (!add) present_q.push_back(all_set);
    endfunction

    task check_present(logic got);
      bit want;
      if (present_q.size() == 0) begin
        report($sformatf("result present=%0b with no query waiting", got));
        return;
      end
      want = present_q.pop_front();
      checked++;
      if (got !== want) report($sformatf("present=%0b, predicted %0b", got, want));
    endtask

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  mode_i;
  logic [7:0]            key_byte_i;
  logic                  last_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  present_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bloom_scoreboard sb;
  key_t            added_keys [$];
  int unsigned     holds_wanted = 0;
  int unsigned     holds_done   = 0;
  int unsigned     bytes_sent   = 0;
  int unsigned     src_quiet    = 0;
  bit              calm_run     = 1'b0;

  int unsigned phase_size  [NUM_PHASES] = '{4096, 1, 0, 8191, 37, 4096, 2000, 8, 4096};
  int unsigned phase_count [NUM_PHASES] = '{4, 1, 16, 31, 0, 16, 17, 5, 4};
  int unsigned phase_items [NUM_PHASES] = '{300, 100, 100, 150, 100, 250, 150, 150, 150};

  bloom_filter_fnv1a_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .key_byte_i  (key_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .present_o   (present_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_byte(logic md, logic [7:0] kb, logic lst);
    if (!calm_run && src_quiet == 0 && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    if (src_quiet > 0) src_quiet--;
    else if ($urandom_range(0, 39) == 0) src_quiet = $urandom_range(20, 60);
    in_valid_i  <= 1'b1;
    mode_i      <= md;
    key_byte_i  <= kb;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(md, kb, lst);
    bytes_sent++;
  endtask

  // only the mode on the final byte counts, earlier ones are random
  task automatic send_key(key_t k, logic last_mode);
    logic md;
    for (int j = 0; j < k.len; j++) begin
      md = (j == k.len - 1) ? last_mode : 1'($urandom_range(0, 1));
      send_byte(md, k.data[8*j +: 8], j == k.len - 1);
    end
  endtask

  function automatic key_t make_key(int unsigned max_len);
    key_t k;
    k.len  = 5'($urandom_range(1, max_len));
    k.data = '0;
    for (int j = 0; j < KEY_MAX; j++) begin
      case ($urandom_range(0, 7))
        0:       k.data[8*j +: 8] = 8'h00;
        1:       k.data[8*j +: 8] = 8'hff;
        default: k.data[8*j +: 8] = 8'($urandom);
      endcase
    end
    return k;
  endfunction

  function automatic key_t key_of(int unsigned len, logic [7:0] b0, logic [7:0] b1,
                                  logic [7:0] b2, logic [7:0] b3);
    key_t k;
    k.len        = 5'(len);
    k.data       = '0;
    k.data[7:0]  = b0;
    k.data[15:8] = b1;
    k.data[23:16] = b2;
    k.data[31:24] = b3;
    return k;
  endfunction

  task automatic send_random_key();
    key_t        k;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      k = make_key(6);
      send_key(k, MODE_ADD);
      added_keys.push_back(k);
      if (added_keys.size() > 64) void'(added_keys.pop_front());
    end else if (pick <= 6 && added_keys.size() > 0) begin
      k = added_keys[$urandom_range(0, added_keys.size() - 1)];
      send_key(k, MODE_QUERY);
    end else if (pick <= 8) begin
      k = make_key(6);
      send_key(k, MODE_QUERY);
    end else begin
      k = make_key(KEY_MAX);
      send_key(k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic cfg_transfer(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic write_config(logic [12:0] size, logic [4:0] count, bit spare);
    in_valid_i <= 1'b0;
    while (sb.present_q.size() != 0) @(posedge clk_i);
    // a final add byte leaves nothing to wait for, so let it drain
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_transfer(CFG_FILTER_SIZE, size);
    cfg_transfer(CFG_HASH_COUNT, {8'($urandom), count});
    if (spare) begin
      cfg_transfer(CFG_SPARE_A, 13'($urandom));
      cfg_transfer(CFG_SPARE_B, 13'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned quiet_left;
    stall_left  = 0;
    quiet_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_wanted) begin
        holds_done++;
        stall_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm_run && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(30, 120);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_present(present_o);
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = 1'b0;
    key_byte_i  = 8'h00;
    last_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FILTER_SIZE;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed keys on the empty store, then add and query back, prefixes included
    send_key(key_of(1, 8'h00, 8'h00, 8'h00, 8'h00), MODE_QUERY);
    send_key(key_of(1, 8'hff, 8'h00, 8'h00, 8'h00), MODE_QUERY);
    send_key(key_of(1, 8'hff, 8'h00, 8'h00, 8'h00), MODE_ADD);
    send_key(key_of(1, 8'hff, 8'h00, 8'h00, 8'h00), MODE_QUERY);
    send_key(key_of(3, 8'h00, 8'h80, 8'h7f, 8'h00), MODE_ADD);
    send_key(key_of(3, 8'h00, 8'h80, 8'h7f, 8'h00), MODE_QUERY);
    send_key(key_of(2, 8'h00, 8'h80, 8'h00, 8'h00), MODE_QUERY);
    send_key(key_of(4, 8'h55, 8'haa, 8'h01, 8'hfe), MODE_ADD);
    send_key(key_of(4, 8'h55, 8'haa, 8'h01, 8'hfe), MODE_QUERY);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_config(13'(phase_size[p]), 5'(phase_count[p]), p == 2);
      if (p == 5) holds_wanted++;
      if (p == NUM_PHASES - 1) calm_run = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < phase_items[p]) send_random_key();
    end

    in_valid_i <= 1'b0;
    while (sb.present_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d key bytes and %0d membership answers", bytes_sent, sb.checked);
    $display("across %0d register settings incl. zero and saturating values, with a long stall",
             NUM_PHASES);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bfnv_pkg.sv
design/bfnv_ram.sv
design/bfnv_div.sv
design/bfnv_dp.sv
design/bfnv_ctrl.sv
design/bloom_filter_fnv1a_core.sv
sim/testbench.sv
